/* rtl/core/hslc_pkg.sv */
package hslc_pkg;

  // Item function codes.
  localparam logic [2:0] FUNC_OPEN    = 3'd0;
  localparam logic [2:0] FUNC_CONNECT = 3'd1;
  localparam logic [2:0] FUNC_BYTE    = 3'd2;
  localparam logic [2:0] FUNC_CLOSED  = 3'd3;
  localparam logic [2:0] FUNC_TICK    = 3'd4;

  // Result action codes.
  localparam logic [1:0] ACT_IDLE      = 2'd0;
  localparam logic [1:0] ACT_SEND      = 2'd1;
  localparam logic [1:0] ACT_WAIT      = 2'd2;
  localparam logic [1:0] ACT_RECONNECT = 2'd3;

  // Parse phases kept per connection.
  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_SPACE  = 3'd1;
  localparam logic [2:0] PH_DIGIT0 = 3'd2;
  localparam logic [2:0] PH_CODE   = 3'd5;
  localparam logic [2:0] PH_FAIL   = 3'd6;

  // Character constants.
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Interim code range.
  localparam logic [9:0] CODE_INTERIM_LO = 10'd100;
  localparam logic [9:0] CODE_INTERIM_HI = 10'd200;

  // Configuration register index.
  localparam logic REG_ACTIVE_CONNECTIONS = 1'b0;

  localparam int unsigned CODE_W = 10;

  typedef struct packed {
    logic [2:0]        phase;
    logic [CODE_W-1:0] accum;
  } parse_t;

  // The protocol tag that opens a status line.
  function automatic logic [7:0] proto_tag(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Advance the line parser by one line byte at position pos.
  function automatic parse_t feed(input parse_t st, input logic [7:0] b,
                                  input logic pos_ok, input logic [2:0] pos);
    parse_t r;
    r = st;
    if (st.phase == PH_PREFIX) begin
      if (pos_ok && b == proto_tag(pos)) begin
        if (pos == 3'd4) begin
          r.phase = PH_SPACE;
        end
      end else begin
        r.phase = PH_FAIL;
      end
    end else if (st.phase == PH_SPACE) begin
      if (b == CHAR_SPACE) begin
        r.phase = PH_DIGIT0;
      end
    end else if (st.phase >= PH_DIGIT0 && st.phase < PH_CODE) begin
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
        r.accum = (st.accum << 3) + (st.accum << 1) + {6'd0, b[3:0]};
        r.phase = st.phase + 3'd1;
      end else begin
        r.accum = '0;
        r.phase = PH_FAIL;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/hslc_item_if.sv */
interface hslc_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] conn_id;
  logic [7:0] rx_byte;

  modport source (output valid, func, conn_id, rx_byte, input ready);
  modport sink (input valid, func, conn_id, rx_byte, output ready);
endinterface

/* rtl/core/hslc_result_if.sv */
interface hslc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        line_done;
  logic        is_interim_line;
  logic [9:0]  status_code;
  logic [31:0] started_total;
  logic [31:0] continued_total;
  logic [31:0] answered_total;

  modport source (output valid, action, line_done, is_interim_line, status_code,
                  started_total, continued_total, answered_total, input ready);
  modport sink (input valid, action, line_done, is_interim_line, status_code,
                started_total, continued_total, answered_total, output ready);
endinterface

/* rtl/core/http_status_line_classifier.sv */
// Classifies HTTP status lines on up to CONNECTIONS interleaved byte streams.
// One transaction carries one event for one connection slot, and the block
// returns exactly one result transaction for each, in order. Items are taken
// one per clock cycle unless the result output stalls or the clearing pass
// runs. The per-connection state memory is read when an item is taken, and
// the result is registered after a compute stage of parse and write-back.
// Back-to-back items on the same slot are served by forwarding the written
// state. After reset the block clears the state memory one entry per cycle,
// holding item ready low throughout the pass; configuration writes are taken meanwhile.
module http_status_line_classifier
  import hslc_pkg::*;
#(
  parameter int unsigned CONNECTIONS = 256,
  parameter int unsigned MAX_LINE    = 8192
) (
  input  logic        clk,
  input  logic        rst,
  hslc_item_if.sink   item,
  hslc_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW     = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam int unsigned LEN_W  = $clog2(MAX_LINE + 1);
  localparam int unsigned WORD_W = LEN_W + 3 + CODE_W + 2;
  localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_LINE);
  localparam logic [16:0]      CONN_LIM  = 17'(CONNECTIONS);
  localparam logic [AW-1:0]    LAST_SLOT = AW'(CONNECTIONS - 1);

  // Configuration register.
  logic [8:0] active_connections;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACTIVE_CONNECTIONS) ? {23'd0, active_connections}
                                                       : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_connections <= 9'd256;
    end else if (psel && penable && pwrite && paddr[2] == REG_ACTIVE_CONNECTIONS) begin
      active_connections <= pwdata[8:0];
    end
  end

  // Clearing pass over the state memory after reset.
  logic          clearing;
  logic [AW-1:0] clear_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == LAST_SLOT) begin
        clearing <= 1'b0;
      end
    end
  end

  // Pipeline control.
  logic s1_valid;
  logic res_valid;
  logic res_free;
  logic advance;
  logic accept;

  assign res_free   = !res_valid || result.ready;
  assign advance    = s1_valid && res_free;
  assign item.ready = !clearing && (!s1_valid || res_free);
  assign accept     = item.valid && item.ready;

  // State memory access.
  logic [16:0]       item_id_ext;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_word;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              slot_wr;
  logic [AW-1:0]     slot_addr;
  logic [WORD_W-1:0] slot_word;

  assign item_id_ext = {9'd0, item.conn_id};
  assign rd_addr     = item_id_ext[AW-1:0];
  assign ram_we      = clearing || slot_wr;
  assign ram_waddr   = clearing ? clear_addr : slot_addr;
  assign ram_wdata   = clearing ? '0 : slot_word;

  hslc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CONNECTIONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  // Item register for the compute stage, with forwarding of a same-slot write.
  logic [2:0]        s1_func;
  logic [7:0]        s1_id;
  logic [7:0]        s1_byte;
  logic              fwd_hit;
  logic [WORD_W-1:0] fwd_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (accept) begin
      fwd_hit <= slot_wr && (slot_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func  <= item.func;
      s1_id    <= item.conn_id;
      s1_byte  <= item.rx_byte;
      fwd_word <= slot_word;
    end
  end

  // Slot state as read, fields split out.
  logic [WORD_W-1:0] cur_word;
  logic [LEN_W-1:0]  cur_len;
  parse_t            cur_parse;
  logic              cur_cr;
  logic              cur_cont;
  logic [16:0]       s1_id_ext;

  assign cur_word  = fwd_hit ? fwd_word : rd_word;
  assign cur_len   = cur_word[WORD_W-1 -: LEN_W];
  assign cur_parse = cur_word[CODE_W+4:2];
  assign cur_cr    = cur_word[1];
  assign cur_cont  = cur_word[0];
  assign s1_id_ext = {9'd0, s1_id};
  assign slot_addr = s1_id_ext[AW-1:0];

  // Registered counters and result.
  logic [31:0] started_count;
  logic [31:0] continued_count;
  logic [31:0] answered_count;
  logic [1:0]  res_action;
  logic        res_done;
  logic        res_interim;
  logic [9:0]  res_code;

  // Next slot state and result for the item in the compute stage.
  logic [LEN_W-1:0] len_next;
  parse_t           parse_next;
  parse_t           parse_mid;
  logic             cr_next;
  logic             cont_next;
  logic             slot_on;
  logic [1:0]       action_next;
  logic             done_next;
  logic             interim_next;
  logic [9:0]       code_next;
  logic [31:0]      started_next;
  logic [31:0]      continued_next;
  logic [31:0]      answered_next;

  always_comb begin
    len_next       = cur_len;
    parse_next     = cur_parse;
    parse_mid      = cur_parse;
    cr_next        = cur_cr;
    cont_next      = cur_cont;
    slot_wr        = 1'b0;
    action_next    = ACT_IDLE;
    done_next      = 1'b0;
    interim_next   = 1'b0;
    code_next      = '0;
    started_next   = started_count;
    continued_next = continued_count;
    answered_next  = answered_count;
    slot_on = ({1'b0, s1_id} < active_connections) && (s1_id_ext < CONN_LIM);

    if (advance && slot_on) begin
      case (s1_func)
        FUNC_OPEN: begin
          slot_wr    = 1'b1;
          len_next   = '0;
          parse_next = '0;
          cr_next    = 1'b0;
          cont_next  = 1'b0;
        end
        FUNC_CONNECT: begin
          started_next = started_count + 32'd1;
          action_next  = ACT_SEND;
        end
        FUNC_CLOSED: begin
          action_next = ACT_RECONNECT;
        end
        FUNC_TICK: begin
          action_next = ACT_WAIT;
        end
        FUNC_BYTE: begin
          if (cur_len < MAX_LEN) begin
            slot_wr = 1'b1;
            if (cur_cr && s1_byte == CHAR_LF) begin
              // End of line; a bare CR LF gives no result flags.
              if (cur_len >= LEN_W'(2)) begin
                done_next = 1'b1;
                code_next = (cur_parse.phase == PH_CODE) ? cur_parse.accum : '0;
                if (code_next >= CODE_INTERIM_LO && code_next < CODE_INTERIM_HI) begin
                  interim_next = 1'b1;
                  if (!cur_cont) begin
                    cont_next      = 1'b1;
                    continued_next = continued_count + 32'd1;
                  end
                end else begin
                  answered_next = answered_count + 32'd1;
                  action_next   = ACT_RECONNECT;
                end
              end
              len_next   = '0;
              parse_next = '0;
              cr_next    = 1'b0;
            end else begin
              len_next = cur_len + 1'b1;
              // A held CR that is not followed by LF is line text.
              if (cur_cr) begin
                parse_mid = feed(cur_parse, CHAR_CR, cur_len <= LEN_W'(5),
                                 cur_len[2:0] - 3'd1);
              end
              if (s1_byte == CHAR_CR) begin
                parse_next = parse_mid;
                cr_next    = 1'b1;
              end else begin
                parse_next = feed(parse_mid, s1_byte, cur_len < LEN_W'(5), cur_len[2:0]);
                cr_next    = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign slot_word = {len_next, parse_next, cr_next, cont_next};

  // Output register and global counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid       <= 1'b0;
      started_count   <= '0;
      continued_count <= '0;
      answered_count  <= '0;
    end else if (advance) begin
      res_valid       <= 1'b1;
      started_count   <= started_next;
      continued_count <= continued_next;
      answered_count  <= answered_next;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_action  <= action_next;
      res_done    <= done_next;
      res_interim <= interim_next;
      res_code    <= code_next;
    end
  end

  assign result.valid           = res_valid;
  assign result.action          = res_action;
  assign result.line_done       = res_done;
  assign result.is_interim_line = res_interim;
  assign result.status_code     = res_code;
  assign result.started_total   = started_count;
  assign result.continued_total = continued_count;
  assign result.answered_total  = answered_count;

endmodule

/* rtl/core/hslc_ram.sv */
module hslc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
